FILE: hw/rtl/rmv_pkg.sv
// ============================================================================
// rmv_pkg
// shared constants, selector codes and controller/datapath command types
// ============================================================================
package rmv_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int MEAN_W   = 40;
    localparam int VAR_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int DISC_W   = 8;

    localparam logic [DISC_W-1:0]  DISC_RESET = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // operand of the squaring unit
    typedef enum logic [1:0] {
        MUL_M  = 2'd0,
        MUL_X  = 2'd1,
        MUL_MN = 2'd2
    } t_mul_sel;

    // dividend of the serial divider
    typedef enum logic {
        DIV_MEAN = 1'b0,
        DIV_VAR  = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     in_ready;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     div_start;
        t_div_sel div_sel;
        logic     form_e;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic is_restart;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hw/rtl/rmv_ifs.sv
// ============================================================================
// rmv interfaces
// valid/ready channels for input items and result items
// ============================================================================
interface rmv_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [rmv_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, kind, sample, input ready);
    modport sink   (input valid, kind, sample, output ready);
endinterface

interface rmv_out_if;
    logic                          valid;
    logic                          ready;
    logic [rmv_pkg::MEAN_W-1:0]    mean;
    logic [rmv_pkg::VAR_W-1:0]     variance;
    logic [rmv_pkg::COUNT_W-1:0]   sample_count;
    logic                          discarded;

    modport source (output valid, mean, variance, sample_count, discarded, input ready);
    modport sink   (input valid, mean, variance, sample_count, discarded, output ready);
endinterface

FILE: hw/rtl/running_mean_variance_core.sv
// ============================================================================
// running_mean_variance_core
// running mean and population variance of unsigned samples, recursive update
// in fixed point, with a startup discard window and restart items
// ============================================================================
//
//  channel   dir  handshake        payload
//  --------  ---  ---------------  ------------------------------------------
//  i_in      in   valid / ready    kind, sample[23:0]
//  o_out     out  valid / ready    mean[39:0], variance[63:0],
//                                  sample_count[31:0], discarded
//  cfg       in   i_cfg_wr_en      i_cfg_wr_data[7:0] (discard_count)
//
//  a sample beat passes, after acceptance, through the square of the old mean,
//  the mean divide, the squares of the sample and of the new mean and the
//  variance divide; NW is the dividend width of the variance divide rounded
//  up to even (82 by default); the two serial divides by the count take two
//  quotient bits a cycle, and the three squares run on one shared multiplier
//  a restart beat goes from S_DECODE straight to the commit step; the next
//  beat is accepted only after the result register loads, so one beat is
//  in flight at a time
//  i_rst_n is synchronous: clears statistics, loads the countdown with 2
//  a stalled o_out holds the finished beat; the next beat is still accepted
//  and waits only at its commit step until the result register frees up
//
module running_mean_variance_core #(
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = rmv_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rmv_pkg::DISC_W-1:0]    i_cfg_wr_data,
    rmv_in_if.sink                        i_in,
    rmv_out_if.source                     o_out
);

    // command and status between sequencer and datapath
    rmv_pkg::t_dp_cmd     w_cmd;
    rmv_pkg::t_dp_status  w_status;

    // sequencer: one state per phase of the update
    rmv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // datapath: state registers, squaring unit, divider, result register
    rmv_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_cmd         (w_cmd),
        .o_status      (w_status)
    );

endmodule

FILE: hw/rtl/rmv_mul.sv
// ============================================================================
// rmv_mul
// squaring unit: three half-width partial products, one per cycle,
// registered and then accumulated
// ============================================================================
module rmv_mul #(
    parameter int OPW = rmv_pkg::SAMPLE_BITS_DEF + rmv_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [OPW-1:0]     i_opnd,
    output logic               o_done,
    output logic [2*OPW-1:0]   o_square
);

    localparam int H   = (OPW + 1) / 2;
    localparam int PH  = 2 * H;
    localparam int PW  = 2 * OPW;
    localparam int SHW = 4 * H;
    localparam int AMW = $clog2(PH + 1);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HH = 2'd2;

    logic            r_busy;
    logic [1:0]      r_step;
    logic [PH-1:0]   r_op;
    logic [PH-1:0]   r_prod;
    logic            r_pv;
    logic            r_plast;
    logic [1:0]      r_pstep;
    logic [PW-1:0]   r_acc;
    logic            r_done;

    logic [H-1:0]    w_fa;
    logic [H-1:0]    w_fb;
    logic [PH-1:0]   w_p;
    logic [AMW-1:0]  w_amt;
    logic [SHW-1:0]  w_sh;

    always_comb begin
        case (r_step)
            STEP_LL: begin
                w_fa = r_op[H-1:0];
                w_fb = r_op[H-1:0];
            end
            STEP_LH: begin
                w_fa = r_op[H-1:0];
                w_fb = r_op[PH-1:H];
            end
            default: begin
                w_fa = r_op[PH-1:H];
                w_fb = r_op[PH-1:H];
            end
        endcase
    end

    assign w_p = PH'(w_fa) * PH'(w_fb);

    // cross term counts twice, so it sits one place higher
    always_comb begin
        case (r_pstep)
            STEP_LL: w_amt = '0;
            STEP_LH: w_amt = AMW'(H + 1);
            default: w_amt = AMW'(PH);
        endcase
    end

    assign w_sh = SHW'(r_prod) << w_amt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= STEP_LL;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_pv    <= r_busy;
            r_plast <= r_busy && (r_step == STEP_HH);
            r_done  <= r_pv && r_plast;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LL;
            end else if (r_busy) begin
                if (r_step == STEP_HH) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_p;
        r_pstep <= r_step;
        if (i_start) begin
            r_op  <= PH'(i_opnd);
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + w_sh[PW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_square = r_acc;

endmodule

FILE: hw/rtl/rmv_div.sv
// ============================================================================
// rmv_div
// serial restoring divider, two quotient bits per cycle
// ============================================================================
module rmv_div #(
    parameter int NW = 82,
    parameter int DW = rmv_pkg::COUNT_W,
    parameter int SW = $clog2(NW / 2 + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [SW-1:0]  i_steps,
    output logic           o_done,
    output logic [NW-1:0]  o_quot
);

    logic [NW-1:0]  r_num;
    logic [DW-1:0]  r_rem;
    logic [NW-1:0]  r_quot;
    logic [DW-1:0]  r_den;
    logic [SW-1:0]  r_cnt;
    logic           r_done;

    logic [DW:0]    w_t1;
    logic [DW:0]    w_t2;
    logic [DW:0]    w_d1;
    logic [DW:0]    w_d2;
    logic           w_ge1;
    logic           w_ge2;
    logic [DW-1:0]  w_r1;
    logic [DW-1:0]  w_r2;

    always_comb begin
        w_t1  = {r_rem, r_num[NW-1]};
        w_ge1 = w_t1 >= {1'b0, r_den};
        w_d1  = w_t1 - {1'b0, r_den};
        w_r1  = w_ge1 ? w_d1[DW-1:0] : w_t1[DW-1:0];
        w_t2  = {w_r1, r_num[NW-2]};
        w_ge2 = w_t2 >= {1'b0, r_den};
        w_d2  = w_t2 - {1'b0, r_den};
        w_r2  = w_ge2 ? w_d2[DW-1:0] : w_t2[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == SW'(1));
            if (i_start) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_rem  <= '0;
            r_quot <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_num  <= {r_num[NW-3:0], 2'b00};
            r_rem  <= w_r2;
            r_quot <= {r_quot[NW-3:0], w_ge1, w_ge2};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/rmv_dp.sv
// ============================================================================
// rmv_dp
// datapath: statistics registers, squaring unit, divider and result register
// ============================================================================
module rmv_dp #(
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = rmv_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rmv_pkg::DISC_W-1:0]    i_cfg_wr_data,
    rmv_in_if.sink                        i_in,
    rmv_out_if.source                     o_out,
    input  rmv_pkg::t_dp_cmd              i_cmd,
    output rmv_pkg::t_dp_status           o_status
);

    localparam int XW  = SAMPLE_BITS + FRAC_BITS;
    localparam int PW  = 2 * XW;
    localparam int AW  = rmv_pkg::VAR_W + FRAC_BITS;
    localparam int LW  = ((AW > PW) ? AW : PW) + 2;
    localparam int VW  = LW + 1;
    localparam int NW  = (LW - 1) + ((LW - 1) % 2);
    localparam int XWE = XW + (XW % 2);
    localparam int SW  = $clog2(NW / 2 + 1);
    localparam int VHI = rmv_pkg::VAR_W + FRAC_BITS;

    // architectural state
    logic [XW-1:0]                 r_mean;
    logic [rmv_pkg::VAR_W-1:0]     r_var;
    logic [rmv_pkg::COUNT_W-1:0]   r_count;
    logic [rmv_pkg::DISC_W-1:0]    r_startup;

    // item being worked on
    logic                          r_kind;
    logic [XW-1:0]                 r_x;
    logic [rmv_pkg::COUNT_W-1:0]   r_n;
    logic                          r_disc;
    logic [PW-1:0]                 r_b;
    logic [PW-1:0]                 r_c;
    logic [PW-1:0]                 r_d;
    logic [XW-1:0]                 r_mnew;
    logic [LW-1:0]                 r_e;
    logic [LW-1:0]                 r_abc;
    logic [LW-1:0]                 r_t;
    rmv_pkg::t_mul_sel             r_mul_sel;
    rmv_pkg::t_div_sel             r_div_sel;
    logic                          r_div_neg;

    // result register
    logic                          r_o_valid;
    logic [rmv_pkg::MEAN_W-1:0]    r_o_mean;
    logic [rmv_pkg::VAR_W-1:0]     r_o_var;
    logic [rmv_pkg::COUNT_W-1:0]   r_o_count;
    logic                          r_o_disc;

    logic                          w_accept;
    logic [rmv_pkg::COUNT_W-1:0]   w_n_next;
    logic [XW-1:0]                 w_mul_op;
    logic                          w_mul_done;
    logic [PW-1:0]                 w_square;
    logic [XW:0]                   w_diff;
    logic [XW:0]                   w_diff_abs;
    logic [LW-1:0]                 w_e_abs;
    logic [NW-1:0]                 w_num_mean;
    logic [NW-1:0]                 w_num_var;
    logic [NW-1:0]                 w_div_num;
    logic [SW-1:0]                 w_div_steps;
    logic                          w_div_done;
    logic [NW-1:0]                 w_quot;
    logic [XW-1:0]                 w_q_mean;
    logic [LW-1:0]                 w_q_var;
    logic [LW-1:0]                 w_a;
    logic [VW-1:0]                 w_v;
    logic [rmv_pkg::VAR_W-1:0]     w_var_new;

    assign w_accept = i_cmd.in_ready && i_in.valid;
    assign w_n_next = (r_count == rmv_pkg::COUNT_MAX) ? rmv_pkg::COUNT_MAX
                                                      : r_count + 1'b1;

    // load the item, run the startup countdown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup <= rmv_pkg::DISC_RESET;
        end else if (i_cfg_wr_en) begin
            r_startup <= i_cfg_wr_data;
        end else if (w_accept && !i_in.kind && (r_startup != '0)) begin
            r_startup <= r_startup - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in.kind;
            r_x    <= {i_in.sample[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
            if (i_in.kind) begin
                r_n    <= '0;
                r_disc <= 1'b0;
            end else if (r_startup != '0) begin
                r_n    <= rmv_pkg::COUNT_W'(1);
                r_disc <= 1'b1;
            end else begin
                r_n    <= w_n_next;
                r_disc <= 1'b0;
            end
        end
    end

    // squaring unit
    always_comb begin
        case (i_cmd.mul_sel)
            rmv_pkg::MUL_M:  w_mul_op = r_mean;
            rmv_pkg::MUL_X:  w_mul_op = r_x;
            rmv_pkg::MUL_MN: w_mul_op = r_mnew;
            default:         w_mul_op = r_mean;
        endcase
    end

    rmv_mul #(
        .OPW (XW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_opnd   (w_mul_op),
        .o_done   (w_mul_done),
        .o_square (w_square)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mul_sel <= i_cmd.mul_sel;
        end
        if (w_mul_done) begin
            case (r_mul_sel)
                rmv_pkg::MUL_M:  r_b <= w_square;
                rmv_pkg::MUL_X:  r_d <= w_square;
                rmv_pkg::MUL_MN: r_c <= w_square;
                default:         r_b <= w_square;
            endcase
        end
    end

    // divider operands: magnitudes, sign kept aside
    assign w_diff     = {1'b0, r_x} - {1'b0, r_mean};
    assign w_diff_abs = w_diff[XW] ? -w_diff : w_diff;
    assign w_num_mean = NW'(w_diff_abs[XW-1:0]) << (NW - XWE);
    assign w_e_abs    = r_e[LW-1] ? -r_e : r_e;
    assign w_num_var  = NW'(w_e_abs[LW-2:0]);

    assign w_div_num   = (i_cmd.div_sel == rmv_pkg::DIV_VAR) ? w_num_var : w_num_mean;
    assign w_div_steps = (i_cmd.div_sel == rmv_pkg::DIV_VAR) ? SW'(NW / 2) : SW'(XWE / 2);

    rmv_div #(
        .NW (NW),
        .DW (rmv_pkg::COUNT_W),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (r_n),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_q_mean = w_quot[XW-1:0];
    assign w_q_var  = {1'b0, w_quot[LW-2:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
            r_div_neg <= (i_cmd.div_sel == rmv_pkg::DIV_VAR) ? r_e[LW-1] : w_diff[XW];
        end
        if (w_div_done) begin
            case (r_div_sel)
                rmv_pkg::DIV_MEAN: r_mnew <= r_div_neg ? (r_mean - w_q_mean)
                                                       : (r_mean + w_q_mean);
                rmv_pkg::DIV_VAR:  r_t    <= r_div_neg ? (-w_q_var) : w_q_var;
                default:           r_t    <= w_q_var;
            endcase
        end
    end

    // variance terms in q(2f)
    assign w_a = LW'({r_var, {FRAC_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.form_e) begin
            r_e   <= LW'(r_d) - w_a - LW'(r_b);
            r_abc <= w_a + LW'(r_b) - LW'(r_c);
        end
    end

    assign w_v = {r_abc[LW-1], r_abc} + {r_t[LW-1], r_t};

    always_comb begin
        if (w_v[VW-1]) begin
            w_var_new = '0;
        end else if (w_v[VW-2:VHI] != '0) begin
            w_var_new = '1;
        end else begin
            w_var_new = w_v[VHI-1:FRAC_BITS];
        end
    end

    // commit statistics and fill the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_var   <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= r_n;
            if (!r_kind) begin
                r_mean <= r_mnew;
                r_var  <= w_var_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_mean  <= rmv_pkg::MEAN_W'(r_kind ? r_mean : r_mnew);
            r_o_var   <= r_kind ? r_var : w_var_new;
            r_o_count <= r_n;
            r_o_disc  <= r_disc;
        end
    end

    assign i_in.ready          = i_cmd.in_ready;
    assign o_out.valid         = r_o_valid;
    assign o_out.mean          = r_o_mean;
    assign o_out.variance      = r_o_var;
    assign o_out.sample_count  = r_o_count;
    assign o_out.discarded     = r_o_disc;

    assign o_status.in_valid   = i_in.valid;
    assign o_status.is_restart = r_kind;
    assign o_status.mul_done   = w_mul_done;
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = !r_o_valid || o_out.ready;

endmodule

FILE: hw/rtl/rmv_ctrl.sv
// ============================================================================
// rmv_ctrl
// sequencer: steps one item through squares, divides and commit
// ============================================================================
module rmv_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rmv_pkg::t_dp_status    i_status,
    output rmv_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DECODE  = 10'b00_0000_0010,
        S_SQ_M    = 10'b00_0000_0100,
        S_DIV_M   = 10'b00_0000_1000,
        S_SQ_X    = 10'b00_0001_0000,
        S_SQ_MN   = 10'b00_0010_0000,
        S_FORM_E  = 10'b00_0100_0000,
        S_START_E = 10'b00_1000_0000,
        S_DIV_E   = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = rmv_pkg::MUL_M;
        o_cmd.div_sel = rmv_pkg::DIV_MEAN;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_restart) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = rmv_pkg::MUL_M;
                    n_state         = S_SQ_M;
                end
            end
            S_SQ_M: begin
                if (i_status.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rmv_pkg::DIV_MEAN;
                    n_state         = S_DIV_M;
                end
            end
            S_DIV_M: begin
                if (i_status.div_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = rmv_pkg::MUL_X;
                    n_state         = S_SQ_X;
                end
            end
            S_SQ_X: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = rmv_pkg::MUL_MN;
                    n_state         = S_SQ_MN;
                end
            end
            S_SQ_MN: begin
                if (i_status.mul_done) begin
                    n_state = S_FORM_E;
                end
            end
            S_FORM_E: begin
                o_cmd.form_e = 1'b1;
                n_state      = S_START_E;
            end
            S_START_E: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = rmv_pkg::DIV_VAR;
                n_state         = S_DIV_E;
            end
            S_DIV_E: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rmv_checker.sv
// ============================================================================
// rmv_checker
// port-level checks on the running statistics core, bound to the top level
// ============================================================================
module rmv_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rmv_pkg::MEAN_W-1:0]    i_out_mean,
    input  logic [rmv_pkg::VAR_W-1:0]     i_out_variance,
    input  logic [rmv_pkg::COUNT_W-1:0]   i_out_count,
    input  logic                          i_out_discarded
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mean)
            && $stable(i_out_variance) && $stable(i_out_count)
            && $stable(i_out_discarded))
        else $error("result beat changed while stalled");

    // one beat in flight: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a beat is in flight");

    // a discarded sample restarts the statistics at count one
    a_disc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_discarded |-> i_out_count == rmv_pkg::COUNT_W'(1))
        else $error("discarded beat without count one");

    // a single sample has no spread
    a_single_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_count == rmv_pkg::COUNT_W'(1)) |-> i_out_variance == '0)
        else $error("nonzero variance at count one");

endmodule

bind running_mean_variance_core rmv_checker u_rmv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_mean      (o_out.mean),
    .i_out_variance  (o_out.variance),
    .i_out_count     (o_out.sample_count),
    .i_out_discarded (o_out.discarded)
);
